@@ hdl/text_console_writer_macros.svh @@
// Assertion macros for the console writer checker.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TXC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("txc check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define TXC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("txc check failed");

`endif

@@ hdl/txc_pkg.sv @@
// Shared constants, request codes and command types of the text console writer.
package txc_pkg;

  localparam int ROWS_DEF        = 25;
  localparam int COLS_DEF        = 80;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int REQ_TYPE_W   = 2;
  localparam int CHAR_W       = 8;
  localparam int CELL_INDEX_W = 11;
  localparam int COLOR_W      = 8;
  localparam int CUR_ROW_W    = 5;
  localparam int CUR_COL_W    = 7;

  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd15;

  localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e               kind;
    logic [CHAR_W-1:0]       char_code;
    logic [CELL_INDEX_W-1:0] cell_index;
  } cmd_t;

endpackage

@@ hdl/txc_if.sv @@
// Valid/ready channel interfaces for console requests and results.
interface txc_req_if;
  import txc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REQ_TYPE_W-1:0]   req_type;
  logic [CHAR_W-1:0]       char_code;
  logic [CELL_INDEX_W-1:0] cell_index;

  modport source (output valid, req_type, char_code, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface txc_rsp_if;
  import txc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    read_char;
  logic [COLOR_W-1:0]   read_color;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic [CUR_COL_W-1:0] cursor_col;
  logic                 scrolled;

  modport source (output valid, read_char, read_color, cursor_row, cursor_col, scrolled,
                  input ready);
  modport sink   (input valid, read_char, read_color, cursor_row, cursor_col, scrolled,
                  output ready);
endinterface

@@ hdl/txc_fifo.sv @@
// Short command queue between the request front and the execution back.
module txc_fifo #(
  parameter int DEPTH = txc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  txc_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  output txc_pkg::cmd_t data_o,
  input  logic          pop_i
);
  import txc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t          entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + NW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/txc_front.sv @@
// Request front: accepts items and turns them into queue commands.
module txc_front #(
  parameter int ROWS = txc_pkg::ROWS_DEF,
  parameter int COLS = txc_pkg::COLS_DEF
) (
  txc_req_if.sink       req_i,
  input  logic          queue_full_i,
  input  logic          init_busy_i,
  output logic          push_o,
  output txc_pkg::cmd_t cmd_o
);
  import txc_pkg::*;

  localparam int CELLS = ROWS * COLS;

  logic index_ok;

  assign index_ok    = (int'(req_i.cell_index) < CELLS);
  assign req_i.ready = !queue_full_i && !init_busy_i;
  assign push_o      = req_i.valid && req_i.ready;

  always_comb begin
    cmd_o.char_code  = req_i.char_code;
    cmd_o.cell_index = req_i.cell_index;
    unique case (req_i.req_type)
      REQ_PUT:   cmd_o.kind = (req_i.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
      REQ_READ:  cmd_o.kind = index_ok ? CMD_READ : CMD_NOP;  // out of range reads as zero
      REQ_CLEAR: cmd_o.kind = CMD_CLEAR;
      default:   cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

@@ hdl/txc_back.sv @@
// Execution back: cell store, cursor, scroll and fill sequencer, result register.
module txc_back #(
  parameter int ROWS = txc_pkg::ROWS_DEF,
  parameter int COLS = txc_pkg::COLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [txc_pkg::COLOR_W-1:0] text_color_i,
  input  logic                        cmd_valid_i,
  input  txc_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  output logic                        init_busy_o,
  txc_rsp_if.source                   rsp_o
);
  import txc_pkg::*;

  localparam int CELLS  = ROWS * COLS;
  localparam int BOTTOM = (ROWS - 1) * COLS;
  localparam int AW     = $clog2(CELLS);
  localparam int CNTW   = $clog2(CELLS + 1);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS + 1);
  localparam int IXW    = (AW > CELL_INDEX_W) ? AW : CELL_INDEX_W;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_PUT,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [CNTW-1:0]     cnt_q;
  logic [RW-1:0]       row_q;
  logic [CW-1:0]       col_q;
  logic [AW-1:0]       base_q;
  logic [CHAR_W-1:0]   char_q;
  logic                put_pend_q;
  logic                res_read_q;
  logic                res_scr_q;
  logic                rsp_valid_q;
  logic [CHAR_W-1:0]   read_char_q;
  logic [COLOR_W-1:0]  read_color_q;
  logic [CUR_ROW_W-1:0] cur_row_q;
  logic [CUR_COL_W-1:0] cur_col_q;
  logic                scrolled_q;

  logic [15:0]         cell_mem [CELLS];
  logic [15:0]         rd_data_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [15:0]         mem_wd;

  logic                row_last, col_full, slot_free;
  logic [IXW-1:0]      idx_ext;

  assign row_last    = (row_q == RW'(ROWS - 1));
  assign col_full    = (col_q == CW'(COLS));
  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign idx_ext     = IXW'(cmd_i.cell_index);
  assign init_busy_o = (state_q == ST_INIT);
  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_char  = read_char_q;
  assign rsp_o.read_color = read_color_q;
  assign rsp_o.cursor_row = cur_row_q;
  assign rsp_o.cursor_col = cur_col_q;
  assign rsp_o.scrolled   = scrolled_q;

  // Cell store port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wa = cnt_q[AW-1:0];
        mem_wd = {RESET_COLOR, SPACE_CODE};
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_PUT: begin
              if (!col_full) begin
                mem_we = 1'b1;
                mem_wa = base_q + AW'(col_q);
              end else if (!row_last) begin
                mem_we = 1'b1;
                mem_wa = base_q + AW'(COLS);
              end
              mem_wd = {text_color_i, cmd_i.char_code};
            end
            CMD_READ: begin
              mem_re = 1'b1;
              mem_ra = idx_ext[AW-1:0];
            end
            default: ;
          endcase
        end
      end
      ST_SCROLL: begin
        // read one row below, write it back one row up in the next cycle
        mem_re = (cnt_q < CNTW'(CELLS));
        mem_ra = cnt_q[AW-1:0];
        mem_we = (cnt_q != CNTW'(COLS));
        mem_wa = AW'(cnt_q - CNTW'(COLS + 1));
        mem_wd = rd_data_q;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = cnt_q[AW-1:0];
        mem_wd = {text_color_i, SPACE_CODE};
      end
      ST_PUT: begin
        mem_we = 1'b1;
        mem_wa = AW'(BOTTOM);
        mem_wd = {text_color_i, char_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= cell_mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cnt_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      base_q       <= '0;
      char_q       <= '0;
      put_pend_q   <= 1'b0;
      res_read_q   <= 1'b0;
      res_scr_q    <= 1'b0;
      rsp_valid_q  <= 1'b0;
      read_char_q  <= '0;
      read_color_q <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      scrolled_q   <= 1'b0;
    end else begin
      if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          if (cnt_q == CNTW'(CELLS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            put_pend_q <= 1'b0;
            res_read_q <= 1'b0;
            res_scr_q  <= 1'b0;
            state_q    <= ST_DONE;
            unique case (cmd_i.kind)
              CMD_PUT: begin
                if (!col_full) begin
                  col_q <= col_q + CW'(1);
                end else if (!row_last) begin
                  row_q  <= row_q + RW'(1);
                  base_q <= base_q + AW'(COLS);
                  col_q  <= CW'(1);
                end else begin
                  put_pend_q <= 1'b1;
                  char_q     <= cmd_i.char_code;
                  res_scr_q  <= 1'b1;
                  col_q      <= '0;
                  cnt_q      <= CNTW'(COLS);
                  state_q    <= ST_SCROLL;
                end
              end
              CMD_NEWLINE: begin
                col_q <= '0;
                if (!row_last) begin
                  row_q  <= row_q + RW'(1);
                  base_q <= base_q + AW'(COLS);
                end else begin
                  res_scr_q <= 1'b1;
                  cnt_q     <= CNTW'(COLS);
                  state_q   <= ST_SCROLL;
                end
              end
              CMD_READ: begin
                res_read_q <= 1'b1;
              end
              CMD_CLEAR: begin
                cnt_q   <= '0;
                state_q <= ST_FILL;
              end
              default: ;
            endcase
          end
        end
        ST_SCROLL: begin
          if (cnt_q == CNTW'(CELLS)) begin
            cnt_q   <= CNTW'(BOTTOM);
            state_q <= ST_FILL;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        ST_FILL: begin
          if (cnt_q == CNTW'(CELLS - 1)) begin
            state_q <= put_pend_q ? ST_PUT : ST_DONE;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        ST_PUT: begin
          col_q   <= CW'(1);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            rsp_valid_q  <= 1'b1;
            read_char_q  <= res_read_q ? rd_data_q[7:0] : '0;
            read_color_q <= res_read_q ? rd_data_q[15:8] : '0;
            cur_row_q    <= CUR_ROW_W'(row_q);
            cur_col_q    <= CUR_COL_W'(col_q);
            scrolled_q   <= res_scr_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/text_console_writer.sv @@
// Text console writer: put, newline, read and nop pass the back through ST_IDLE and ST_DONE;
// the back takes no new command until the result of the last one is registered.
// A scroll copies every row up one row, then fills the bottom row with blanks, and for a
// wrap then places the wrapped character; clear writes blanks over all ROWS*COLS cells.
// Reset clears control state, then a clearing pass writes blanks over all ROWS*COLS cells
// while req_i.ready stays low; text_color resets to 15.
module text_console_writer #(
  parameter int ROWS        = txc_pkg::ROWS_DEF,
  parameter int COLS        = txc_pkg::COLS_DEF,
  parameter int QUEUE_DEPTH = txc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  txc_req_if.sink                     req_i,
  txc_rsp_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [txc_pkg::COLOR_W-1:0] cfg_wdata_i
);
  import txc_pkg::*;

  // Attribute byte applied to every character put and to the blanks from clear and scroll fill.
  logic [COLOR_W-1:0] text_color_q;

  // Front to queue.
  logic queue_full;
  logic push;
  cmd_t push_cmd;

  // Queue to back.
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Back reports the post-reset clearing pass so the front can hold off requests.
  logic init_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= RESET_COLOR;
    end else if (cfg_we_i) begin
      text_color_q <= cfg_wdata_i;
    end
  end

  // Accept and classify: newline, put, in-range read, clear, or nothing.
  txc_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .req_i        (req_i),
    .queue_full_i (queue_full),
    .init_busy_i  (init_busy),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Decouple: the front keeps taking items while the back runs a long scroll, until the queue fills.
  txc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (queue_full),
    .valid_o (cmd_valid),
    .data_o  (cmd),
    .pop_i   (cmd_pop)
  );

  // Execute against the cell store and hold the result until taken.
  txc_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_color_i (text_color_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .init_busy_o  (init_busy),
    .rsp_o        (rsp_o)
  );

endmodule

@@ hdl/txc_checker.sv @@
// Port-level checker for the text console writer, bound to the top level.
`include "text_console_writer_macros.svh"

module txc_checker #(
  parameter int ROWS = txc_pkg::ROWS_DEF,
  parameter int COLS = txc_pkg::COLS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [txc_pkg::CHAR_W-1:0]    rsp_read_char_i,
  input logic [txc_pkg::COLOR_W-1:0]   rsp_read_color_i,
  input logic [txc_pkg::CUR_ROW_W-1:0] rsp_cursor_row_i,
  input logic [txc_pkg::CUR_COL_W-1:0] rsp_cursor_col_i,
  input logic                          rsp_scrolled_i
);
  import txc_pkg::*;

  // A stalled result stays valid and keeps its cursor position and read character.
  `TXC_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_cursor_col_i) && $stable(rsp_cursor_row_i) && $stable(rsp_read_char_i))

  // The column never passes the line-full mark.
  `TXC_ASSERT_IMPL(a_col_bound, rsp_valid_i, {1'b0, rsp_cursor_col_i} <= 8'(COLS))

  // A scroll always leaves the cursor on the bottom row.
  `TXC_ASSERT_IMPL(a_scroll_row, rsp_valid_i && rsp_scrolled_i, rsp_cursor_row_i == CUR_ROW_W'(ROWS - 1))

  // Read data shows up only for reads, which never scroll.
  `TXC_ASSERT_IMPL(a_read_no_scroll, rsp_valid_i && (rsp_read_char_i != '0 || rsp_read_color_i != '0), !rsp_scrolled_i)

  // The clearing pass holds off requests right after reset.
  `TXC_ASSERT_IMPL(a_init_blocks, $rose(rst_ni), !req_ready_i)

endmodule

bind text_console_writer txc_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_txc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_read_char_i  (rsp_o.read_char),
  .rsp_read_color_i (rsp_o.read_color),
  .rsp_cursor_row_i (rsp_o.cursor_row),
  .rsp_cursor_col_i (rsp_o.cursor_col),
  .rsp_scrolled_i   (rsp_o.scrolled)
);

@@ sim/tb_text_console_writer.sv @@
// Self-checking testbench for the text console writer: shadow screen predictor, random traffic.
module tb_text_console_writer;
  import txc_pkg::*;

  localparam int ROWS  = ROWS_DEF;
  localparam int COLS  = COLS_DEF;
  localparam int CELLS = ROWS * COLS;

  // The request field allows a fourth code that the block must treat as a no-op.
  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

  localparam int          PHASES       = 6;
  localparam int          PHASE_ITEMS  = 200;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          MAX_REPORTS  = 10;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    logic [CHAR_W-1:0]    read_char;
    logic [COLOR_W-1:0]   read_color;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;
    logic                 scrolled;
  } console_rsp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [COLOR_W-1:0]   cfg_wdata_i;

  txc_req_if req_if ();
  txc_rsp_if rsp_if ();

  text_console_writer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the screen, cursor and color register.
  logic [COLOR_W+CHAR_W-1:0] screen_shadow [CELLS];
  int                        shadow_row;
  int                        shadow_col;
  logic [COLOR_W-1:0]        shadow_color;

  // Results still owed by the block, oldest first.
  console_rsp_t console_rsp_q [$];

  bit          req_gaps_on   = 1'b1;
  bit          rsp_stalls_on = 1'b1;
  int unsigned hold_left     = 0;

  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned rsp_checked   = 0;
  int unsigned reads_sent    = 0;
  int unsigned clears_sent   = 0;
  int unsigned wraps_sent    = 0;
  int unsigned scrolls_seen  = 0;
  int unsigned color_writes  = 0;
  int unsigned cycle_count   = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Fill one row with spaces in the current color.
  function automatic void blank_row(int row);
    for (int c = 0; c < COLS; c++) begin
      screen_shadow[row * COLS + c] = {shadow_color, SPACE_CODE};
    end
  endfunction

  // Move to column 0 of the next row; on the last row shift the screen up.
  function automatic bit advance_line();
    shadow_col = 0;
    if (shadow_row < ROWS - 1) begin
      shadow_row++;
      return 1'b0;
    end
    for (int i = COLS; i < CELLS; i++) begin
      screen_shadow[i - COLS] = screen_shadow[i];
    end
    blank_row(ROWS - 1);
    return 1'b1;
  endfunction

  function automatic void reset_shadow();
    shadow_color = RESET_COLOR;
    shadow_row   = 0;
    shadow_col   = 0;
    for (int r = 0; r < ROWS; r++) begin
      blank_row(r);
    end
  endfunction

  // Apply one request to the shadow screen and return the result it must produce.
  function automatic console_rsp_t console_step(logic [REQ_TYPE_W-1:0] kind,
                                                logic [CHAR_W-1:0] ch,
                                                logic [CELL_INDEX_W-1:0] idx);
    console_rsp_t r;
    r = '0;
    case (kind)
      REQ_PUT: begin
        if (ch == NEWLINE_CODE) begin
          r.scrolled = advance_line();
        end else begin
          // A full line takes an implicit newline before the character lands.
          if (shadow_col >= COLS) begin
            r.scrolled = advance_line();
            wraps_sent++;
          end
          screen_shadow[shadow_row * COLS + shadow_col] = {shadow_color, ch};
          shadow_col++;
        end
      end
      REQ_READ: begin
        // Out-of-range cells read back as zero.
        if (idx < CELLS) begin
          {r.read_color, r.read_char} = screen_shadow[idx];
        end
      end
      REQ_CLEAR: begin
        for (int row = 0; row < ROWS; row++) begin
          blank_row(row);
        end
      end
      default: begin
      end
    endcase
    r.cursor_row = shadow_row[CUR_ROW_W-1:0];
    r.cursor_col = shadow_col[CUR_COL_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    console_rsp_t got;
    console_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.read_char, rsp_if.read_color, rsp_if.cursor_row,
             rsp_if.cursor_col, rsp_if.scrolled};
      if (got.scrolled) begin
        scrolls_seen++;
      end
      if (console_rsp_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result: char %02h color %02h row %0d col %0d scr %0b",
                               got.read_char, got.read_color, got.cursor_row,
                               got.cursor_col, got.scrolled));
      end else begin
        want = console_rsp_q.pop_front();
        if (got.read_char !== want.read_char || got.read_color !== want.read_color ||
            got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
            got.scrolled !== want.scrolled) begin
          log_mismatch($sformatf({"result %0d: expected char %02h color %02h row %0d col %0d",
                                  " scr %0b, got char %02h color %02h row %0d col %0d scr %0b"},
                                 rsp_checked, want.read_char, want.read_color,
                                 want.cursor_row, want.cursor_col, want.scrolled,
                                 got.read_char, got.read_color, got.cursor_row,
                                 got.cursor_col, got.scrolled));
        end
      end
      rsp_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per result, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  // Count down a requested hold-off by one at each clock edge.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin : rsp_drain
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = rsp_stalls_on ? $urandom_range(0, 7) : 0;
      // Hold ready low for the drawn stall and for any pending hold-off.
      while (stall > 0 || hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        @(posedge clk_i);
        if (stall > 0) begin
          stall--;
        end
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) begin
        @(posedge clk_i);
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
               console_rsp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap; predict its result once it is accepted.
  task automatic send_req(input logic [REQ_TYPE_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                          input logic [CELL_INDEX_W-1:0] idx);
    int gap;
    gap = req_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.char_code  <= ch;
    req_if.cell_index <= idx;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    console_rsp_q.push_back(console_step(kind, ch, idx));
    items_sent++;
    if (kind == REQ_READ) begin
      reads_sent++;
    end
    if (kind == REQ_CLEAR) begin
      clears_sent++;
    end
  endtask

  // Drop valid and wait until every owed result is back and the block takes requests.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (console_rsp_q.size() != 0 || !req_if.ready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_text_color(input logic [COLOR_W-1:0] color);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= color;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_color = color;
    color_writes++;
  endtask

  function automatic logic [CHAR_W-1:0] text_char();
    logic [CHAR_W-1:0] ch;
    ch = CHAR_W'($urandom_range(0, 255));
    // Keep text runs free of line breaks; substitute a space.
    if (ch == NEWLINE_CODE) begin
      ch = SPACE_CODE;
    end
    return ch;
  endfunction

  function automatic logic [CELL_INDEX_W-1:0] any_index();
    return CELL_INDEX_W'($urandom_range(0, (1 << CELL_INDEX_W) - 1));
  endfunction

  // Aim half the reads at the cursor row and the bottom two rows, the rest anywhere, in or out of range.
  function automatic logic [CELL_INDEX_W-1:0] read_target();
    case ($urandom_range(0, 3))
      0: return CELL_INDEX_W'(shadow_row * COLS + $urandom_range(0, COLS - 1));
      1: return CELL_INDEX_W'($urandom_range(ROWS - 2, ROWS - 1) * COLS +
                              $urandom_range(0, COLS - 1));
      2: return CELL_INDEX_W'($urandom_range(0, CELLS - 1));
      default: return any_index();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset contents: blank corners, out-of-range reads and the unused request code.
  task automatic test_reset_contents();
    send_req(REQ_READ, 8'h00, '0);
    send_req(REQ_READ, 8'hFF, CELL_INDEX_W'(CELLS - 1));
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'(CELLS));
    send_req(REQ_READ, 8'h00, '1);
    send_req(REQ_UNUSED, 8'hFF, '1);
  endtask

  // Extreme characters in extreme colors, then read them back.
  task automatic test_put_extremes();
    set_text_color(8'h00);
    send_req(REQ_PUT, 8'h00, '0);
    send_req(REQ_PUT, 8'hFF, '1);
    set_text_color(8'hFF);
    send_req(REQ_PUT, 8'h7E, '0);
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'(0));
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'(1));
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'(2));
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'(3));
  endtask

  // Clear blanks the screen in the current color and leaves the cursor alone.
  task automatic test_clear_keeps_cursor();
    set_text_color(8'hA5);
    send_req(REQ_CLEAR, 8'h00, '0);
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'(0));
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'(CELLS - 1));
    send_req(REQ_PUT, NEWLINE_CODE, '0);
    send_req(REQ_PUT, 8'h5A, '0);
  endtask

  // Hold the receiver off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    req_gaps_on = 1'b0;
    hold_left <= HOLD_CYCLES;
    repeat (24) begin
      send_req(REQ_PUT, text_char(), any_index());
    end
    repeat (4) begin
      send_req(REQ_READ, 8'h00, read_target());
    end
    req_gaps_on = 1'b1;
  endtask

  // Run past a full line, walk down to the last row, scroll by newline and by wrap.
  task automatic test_wrap_and_scroll();
    set_text_color(COLOR_W'($urandom_range(0, 255)));
    send_req(REQ_PUT, NEWLINE_CODE, any_index());
    repeat (COLS + 3) begin
      send_req(REQ_PUT, text_char(), any_index());
    end
    while (shadow_row < ROWS - 1) begin
      send_req(REQ_PUT, NEWLINE_CODE, any_index());
    end
    set_text_color(COLOR_W'($urandom_range(0, 255)));
    repeat (2) begin
      send_req(REQ_PUT, NEWLINE_CODE, any_index());
    end
    repeat (COLS + 1) begin
      send_req(REQ_PUT, text_char(), any_index());
    end
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'((ROWS - 1) * COLS));
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'((ROWS - 1) * COLS + 1));
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'((ROWS - 2) * COLS + COLS - 1));
    send_req(REQ_READ, 8'h00, CELL_INDEX_W'((ROWS - 3) * COLS));
  endtask

  // One random burst: a text run, a group of reads, a clear, or noise.
  task automatic send_random_burst();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(20, 100);
      repeat (len) begin
        send_req(REQ_PUT, text_char(), any_index());
      end
      if ($urandom_range(0, 1) == 1) begin
        send_req(REQ_PUT, NEWLINE_CODE, any_index());
      end
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 6)) begin
        send_req(REQ_READ, CHAR_W'($urandom_range(0, 255)), read_target());
      end
    end else if (pick < 95) begin
      send_req(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)), any_index());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_req(REQ_TYPE_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                 any_index());
      end
    end
  endtask

  // Random traffic in phases; each phase gets its own color and idling mix.
  task automatic test_random_traffic();
    int unsigned phase_end;
    logic [COLOR_W-1:0] color;
    for (int p = 0; p < PHASES; p++) begin
      color = (p == 0) ? 8'h00 : (p == PHASES - 1) ? 8'hFF :
              COLOR_W'($urandom_range(0, 255));
      set_text_color(color);
      // Alternate idling: both sides idle, neither, or only the receiver.
      req_gaps_on   = (p % 3 != 1) && (p != 2);
      rsp_stalls_on = (p % 3 != 1);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        send_random_burst();
      end
    end
    req_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_shadow();
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_PUT;
    req_if.char_code  <= '0;
    req_if.cell_index <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reads first: they also wait out the clearing pass before any color write.
    test_reset_contents();
    test_put_extremes();
    test_clear_keeps_cursor();
    test_backpressure();
    test_wrap_and_scroll();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (console_rsp_q.size() != 0) begin
      log_mismatch($sformatf("%0d results never arrived", console_rsp_q.size()));
    end

    $display("Ran %0d requests (%0d reads, %0d clears, %0d line wraps), %0d results checked",
             items_sent, reads_sent, clears_sent, wraps_sent, rsp_checked);
    $display("Saw %0d scrolls over %0d color settings, one %0d-cycle receiver hold-off",
             scrolls_seen, color_writes, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ text_console_writer.f @@
+incdir+hdl
hdl/txc_pkg.sv
hdl/txc_if.sv
hdl/txc_fifo.sv
hdl/txc_front.sv
hdl/txc_back.sv
hdl/text_console_writer.sv
hdl/txc_checker.sv
sim/tb_text_console_writer.sv
